/* rtl/lqp_pkg.sv */
// ---------------------------------------------------------------------------
// lqp_pkg
// Shared types and codes for the linked queue pool engine: request and
// result items, command codes, controller states and datapath operations.
// ---------------------------------------------------------------------------
`default_nettype none

package lqp_pkg;

	localparam int CMD_W  = 2;
	localparam int CORE_W = 2;
	localparam int NODE_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_POP    = 2'd0,
		CMD_PUSH   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} lqp_cmd_t;

	typedef struct packed {
		lqp_cmd_t            command;
		logic [CORE_W-1:0]   core_index;
		logic                queue_select;
		logic [NODE_W-1:0]   node_id;
	} lqp_req_t;

	typedef struct packed {
		logic [NODE_W-1:0]   node_out;
		logic                status;
	} lqp_res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_RD,
		ST_POP_WR,
		ST_PUSH_TAIL,
		ST_PUSH_FIN,
		ST_WALK,
		ST_WALK_ADV,
		ST_UNLINK,
		ST_UNLINK_FIN,
		ST_OK,
		ST_FAIL
	} lqp_state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLR,
		OP_LOAD,
		OP_RD_CUR,
		OP_POP_FIN,
		OP_PUSH_TAIL,
		OP_PUSH_FIN,
		OP_ADV,
		OP_UNLINK,
		OP_UNLINK_FIN,
		OP_DONE_OK,
		OP_DONE_FAIL
	} lqp_op_t;

	// datapath flags seen by the controller
	typedef struct packed {
		lqp_cmd_t  cmd;
		logic      core_bad;
		logic      node_bad;
		logic      cur_null;
		logic      cur_match;
		logic      steps_done;
		logic      clr_last;
	} lqp_stat_t;

endpackage

`default_nettype wire

/* rtl/linked_queue_pool_engine.sv */
// ---------------------------------------------------------------------------
// linked_queue_pool_engine
// Per-core node pools threaded into a free queue and a work queue through a
// shared next-link memory. Pop, push-to-tail and remove-by-walk.
//
//   channel   ports                    handshake
//   request   start, busy, request     taken when start && !busy
//   result    done, result             one-cycle strobe, no backpressure
//
// Pop reads the head's link and then unlinks the head; push links the node
// behind the tail and then ends it; remove walks from the head until it meets
// the node, runs off the end or has followed NODES links; a refused request
// fails and an unknown one succeeds, neither touching the queues. The walk
// is bound by the single read port of the link memory (read, then advance).
// After reset busy stays high while the link memory is swept into its
// initial chains.
// The result strobe shows while the engine is already idle, so a new item
// may be started in that same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module linked_queue_pool_engine #(
	parameter int NODES = 16,
	parameter int CORES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lqp_pkg::lqp_req_t request,
	output logic                   done,
	output lqp_pkg::lqp_res_t      result
);
	import lqp_pkg::*;

	lqp_op_t   op;
	lqp_stat_t stat;

	lqp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	lqp_datapath #(
		.NODES (NODES),
		.CORES (CORES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.req    (request),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

/* rtl/lqp_datapath.sv */
// ---------------------------------------------------------------------------
// lqp_datapath
// Queue head/tail registers, the shared next-link memory, the walk registers
// and the result register. Performs one operation per cycle as commanded.
// ---------------------------------------------------------------------------
`default_nettype none

module lqp_datapath #(
	parameter int NODES = 16,
	parameter int CORES = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lqp_pkg::lqp_op_t  op,
	input  wire lqp_pkg::lqp_req_t req,
	output lqp_pkg::lqp_stat_t     stat,
	output logic                   done,
	output lqp_pkg::lqp_res_t      result
);
	import lqp_pkg::*;

	localparam int QSLOTS = CORES * 2;
	localparam int LSLOTS = CORES * NODES;
	localparam int LW     = $clog2(NODES + 1);
	localparam int AW     = $clog2(LSLOTS);
	localparam int QW     = $clog2(QSLOTS);
	localparam logic [LW-1:0] LNULL     = LW'(NODES);
	localparam logic [LW-1:0] LAST_NODE = LW'(NODES - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(LSLOTS - 1);

	logic [LW-1:0] head_q [QSLOTS];
	logic [LW-1:0] tail_q [QSLOTS];
	logic [LW-1:0] link_mem [LSLOTS];

	lqp_cmd_t      cmd_q;
	logic          core_bad_q;
	logic          node_bad_q;
	logic [QW-1:0] q_q;
	logic [AW-1:0] base_q;
	logic [LW-1:0] node_q;
	logic [NODE_W-1:0] nout_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [LW-1:0] steps_q;
	logic [LW-1:0] rdata_q;
	logic [AW-1:0] clr_addr_q;
	logic [LW-1:0] clr_node_q;
	logic          done_q;
	lqp_res_t      res_q;

	logic [QW-1:0] req_q_idx;
	logic          req_core_bad;
	logic          tail_null;
	logic          prev_null;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [LW-1:0] mem_wd;

	assign req_q_idx    = QW'({req.core_index, req.queue_select});
	assign req_core_bad = 32'(req.core_index) >= CORES;
	assign tail_null    = tail_q[q_q] >= LNULL;
	assign prev_null    = prev_q >= LNULL;

	// write/read port selection
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = LNULL;
		mem_ra = base_q + AW'(cur_q);
		case (op)
			OP_CLR: begin
				mem_we = 1'b1;
				mem_wd = (clr_node_q == LAST_NODE) ? LNULL : clr_node_q + LW'(1);
			end
			OP_RD_CUR: begin
				mem_re = 1'b1;
			end
			OP_POP_FIN, OP_UNLINK_FIN: begin
				mem_we = 1'b1;
				mem_wa = base_q + AW'(cur_q);
			end
			OP_PUSH_TAIL: begin
				mem_we = !tail_null;
				mem_wa = base_q + AW'(tail_q[q_q]);
				mem_wd = node_q;
			end
			OP_PUSH_FIN: begin
				mem_we = 1'b1;
				mem_wa = base_q + AW'(node_q);
			end
			OP_UNLINK: begin
				mem_we = !prev_null;
				mem_wa = base_q + AW'(prev_q);
				mem_wd = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= link_mem[mem_ra];
		end
	end

	// queue heads and tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QSLOTS; i++) begin
				head_q[i] <= (i % 2 == 0) ? '0 : LNULL;
				tail_q[i] <= (i % 2 == 0) ? LAST_NODE : LNULL;
			end
		end else begin
			case (op)
				OP_POP_FIN: begin
					head_q[q_q] <= rdata_q;
					if (rdata_q >= LNULL) begin
						tail_q[q_q] <= LNULL;
					end
				end
				OP_PUSH_TAIL: begin
					if (tail_null) begin
						head_q[q_q] <= node_q;
					end
				end
				OP_PUSH_FIN: begin
					tail_q[q_q] <= node_q;
				end
				OP_UNLINK: begin
					if (prev_null) begin
						head_q[q_q] <= rdata_q;
					end
					if (tail_q[q_q] == cur_q) begin
						tail_q[q_q] <= prev_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// link store initialization sweep and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_node_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (op == OP_DONE_OK) || (op == OP_DONE_FAIL);
			if (op == OP_CLR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				clr_node_q <= (clr_node_q == LAST_NODE) ? '0 : clr_node_q + LW'(1);
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q      <= req.command;
				core_bad_q <= req_core_bad;
				node_bad_q <= 32'(req.node_id) >= NODES;
				q_q        <= req_q_idx;
				base_q     <= AW'(32'(req.core_index) * NODES);
				node_q     <= LW'(req.node_id);
				nout_q     <= req.node_id;
				cur_q      <= req_core_bad ? LNULL : head_q[req_q_idx];
				prev_q     <= LNULL;
				steps_q    <= '0;
			end
			OP_ADV: begin
				prev_q  <= cur_q;
				cur_q   <= rdata_q;
				steps_q <= steps_q + LW'(1);
			end
			OP_POP_FIN: begin
				nout_q <= NODE_W'(cur_q);
			end
			OP_DONE_OK, OP_DONE_FAIL: begin
				res_q.node_out <= nout_q;
				res_q.status   <= op == OP_DONE_FAIL;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.core_bad   = core_bad_q;
		stat.node_bad   = node_bad_q;
		stat.cur_null   = cur_q >= LNULL;
		stat.cur_match  = cur_q == node_q;
		stat.steps_done = steps_q == LW'(NODES);
		stat.clr_last   = clr_addr_q == LAST_ADDR;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* rtl/lqp_ctrl.sv */
// ---------------------------------------------------------------------------
// lqp_ctrl
// Controller: sequences the link store sweep after reset, then runs pop,
// push and remove as a series of datapath operations.
// ---------------------------------------------------------------------------
`default_nettype none

module lqp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire lqp_pkg::lqp_stat_t stat,
	output lqp_pkg::lqp_op_t        op,
	output logic                    busy
);
	import lqp_pkg::*;

	lqp_state_t state_q;
	lqp_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (stat.core_bad) begin
					state_nxt = ST_FAIL;
				end else begin
					case (stat.cmd)
						CMD_POP:    state_nxt = stat.cur_null ? ST_FAIL : ST_POP_RD;
						CMD_PUSH:   state_nxt = stat.node_bad ? ST_FAIL : ST_PUSH_TAIL;
						CMD_REMOVE: state_nxt = stat.node_bad ? ST_FAIL : ST_WALK;
						default:    state_nxt = ST_OK;
					endcase
				end
			end
			ST_POP_RD:     state_nxt = ST_POP_WR;
			ST_POP_WR:     state_nxt = ST_OK;
			ST_PUSH_TAIL:  state_nxt = ST_PUSH_FIN;
			ST_PUSH_FIN:   state_nxt = ST_OK;
			ST_WALK: begin
				if (stat.cur_null || stat.steps_done) begin
					state_nxt = ST_FAIL;
				end else if (stat.cur_match) begin
					state_nxt = ST_UNLINK;
				end else begin
					state_nxt = ST_WALK_ADV;
				end
			end
			ST_WALK_ADV:   state_nxt = ST_WALK;
			ST_UNLINK:     state_nxt = ST_UNLINK_FIN;
			ST_UNLINK_FIN: state_nxt = ST_OK;
			ST_OK:         state_nxt = ST_IDLE;
			ST_FAIL:       state_nxt = ST_IDLE;
			default:       state_nxt = ST_INIT;
		endcase
	end

	always_comb begin
		op   = OP_NOP;
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_INIT:       op = OP_CLR;
			ST_IDLE:       op = start ? OP_LOAD : OP_NOP;
			ST_POP_RD:     op = OP_RD_CUR;
			ST_POP_WR:     op = OP_POP_FIN;
			ST_PUSH_TAIL:  op = OP_PUSH_TAIL;
			ST_PUSH_FIN:   op = OP_PUSH_FIN;
			ST_WALK: begin
				// fetch the link of the current node: the next hop, or the
				// successor to splice in when this is the node
				if (!stat.cur_null && !stat.steps_done) op = OP_RD_CUR;
			end
			ST_WALK_ADV:   op = OP_ADV;
			ST_UNLINK:     op = OP_UNLINK;
			ST_UNLINK_FIN: op = OP_UNLINK_FIN;
			ST_OK:         op = OP_DONE_OK;
			ST_FAIL:       op = OP_DONE_FAIL;
			default:       op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/lqp_checker.sv */
// ---------------------------------------------------------------------------
// lqp_checker
// Port-level checks on the engine's request/result sequencing.
// ---------------------------------------------------------------------------
`default_nettype none

module lqp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire lqp_pkg::lqp_res_t result
);
	import lqp_pkg::*;

	// every item passes through dispatch and a final state after acceptance, so strobes never abut
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine not busy after taking an item");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after accept");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a busy item");

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result carries unknown bits");

endmodule

bind linked_queue_pool_engine lqp_checker u_lqp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for linked_queue_pool_engine. A generator fills a queue
// of requests (directed corner cases, then steered random traffic), a driver
// issues them with random gaps, and a monitor compares every result strobe
// against a queue-pool model updated as each item is taken.
// ---------------------------------------------------------------------------

module testbench;
	import lqp_pkg::*;

	localparam int NODES  = 16;
	localparam int CORES  = 4;
	localparam int QUEUES = CORES * 2;

	typedef logic [NODE_W:0]   link_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef node_t             node_list_t[$];

	localparam link_t LINK_END = link_t'(NODES);

	typedef struct packed {
		lqp_req_t   req;
		logic [2:0] gap;
		logic       drain;
	} queued_req_t;

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	lqp_req_t request = '0;
	logic     busy;
	logic     done;
	lqp_res_t result;

	// pool model: head/tail per queue, next link per node
	link_t head_ptr [QUEUES];
	link_t tail_ptr [QUEUES];
	link_t next_ptr [CORES*NODES];

	queued_req_t pending[$];
	lqp_res_t    results_due[$];
	lqp_res_t    want;
	int          idle_left   = 0;
	int          error_count = 0;
	bit          quiet       = 1'b0;

	linked_queue_pool_engine #(
		.NODES(NODES),
		.CORES(CORES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void pool_reset();
		for (int c = 0; c < CORES; c++) begin
			head_ptr[2*c]   = link_t'(0);
			tail_ptr[2*c]   = link_t'(NODES - 1);
			head_ptr[2*c+1] = LINK_END;
			tail_ptr[2*c+1] = LINK_END;
			for (int n = 0; n < NODES; n++)
				next_ptr[c*NODES+n] = (n + 1 < NODES) ? link_t'(n + 1) : LINK_END;
		end
	endfunction

	function automatic link_t link_rd(int base, link_t n);
		if (n >= LINK_END)
			return LINK_END;
		return next_ptr[base+int'(n)];
	endfunction

	function automatic void link_wr(int base, link_t n, link_t v);
		if (n < LINK_END)
			next_ptr[base+int'(n)] = v;
	endfunction

	// applies one request to the pool model and returns its result
	function automatic lqp_res_t serve_request(lqp_req_t r);
		lqp_res_t res;
		int       q;
		int       base;
		int       steps;
		link_t    cur;
		link_t    prev;
		link_t    nx;
		link_t    node;
		bit       found;
		res.node_out = r.node_id;
		res.status   = 1'b0;
		q    = 2 * int'(r.core_index) + int'(r.queue_select);
		base = int'(r.core_index) * NODES;
		node = link_t'(r.node_id);
		if (int'(r.core_index) >= CORES) begin
			res.status = 1'b1;
		end else begin
			case (r.command)
				CMD_POP: begin
					cur = head_ptr[q];
					if (cur >= LINK_END) begin
						res.status = 1'b1;
					end else begin
						nx = link_rd(base, cur);
						head_ptr[q] = nx;
						if (nx >= LINK_END)
							tail_ptr[q] = LINK_END;
						link_wr(base, cur, LINK_END);
						res.node_out = cur[NODE_W-1:0];
					end
				end
				CMD_PUSH: begin
					if (node >= LINK_END) begin
						res.status = 1'b1;
					end else begin
						if (tail_ptr[q] >= LINK_END)
							head_ptr[q] = node;
						else
							link_wr(base, tail_ptr[q], node);
						link_wr(base, node, LINK_END);
						tail_ptr[q] = node;
					end
				end
				CMD_REMOVE: begin
					found = 1'b0;
					cur   = head_ptr[q];
					prev  = LINK_END;
					steps = 0;
					// walk is bounded so a malformed queue still terminates
					while (node < LINK_END && !found && cur < LINK_END && steps < NODES) begin
						if (cur == node) begin
							nx = link_rd(base, cur);
							if (prev >= LINK_END)
								head_ptr[q] = nx;
							else
								link_wr(base, prev, nx);
							if (cur == tail_ptr[q])
								tail_ptr[q] = prev;
							link_wr(base, cur, LINK_END);
							found = 1'b1;
						end else begin
							prev = cur;
							cur  = link_rd(base, cur);
							steps++;
						end
					end
					res.status = !found;
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	function automatic node_list_t queue_nodes(int c, int qs);
		node_list_t nodes;
		link_t      cur;
		int         steps;
		cur   = head_ptr[2*c+qs];
		steps = 0;
		while (cur < LINK_END && steps < NODES) begin
			nodes.push_back(cur[NODE_W-1:0]);
			cur = link_rd(c * NODES, cur);
			steps++;
		end
		return nodes;
	endfunction

	// nodes of a core reachable from neither of its queues
	function automatic node_list_t loose_nodes(int c);
		node_list_t       held;
		node_list_t       spare;
		bit [NODES-1:0]   owned;
		owned = '0;
		held  = queue_nodes(c, 0);
		foreach (held[k]) owned[held[k]] = 1'b1;
		held = queue_nodes(c, 1);
		foreach (held[k]) owned[held[k]] = 1'b1;
		for (int n = 0; n < NODES; n++)
			if (!owned[n])
				spare.push_back(node_t'(n));
		return spare;
	endfunction

	// queues one request and advances the model so later picks can be steered
	function automatic void add_item(lqp_cmd_t cmd, int c, int qs, int n, bit drain);
		queued_req_t item;
		item.req.command      = cmd;
		item.req.core_index   = c[CORE_W-1:0];
		item.req.queue_select = qs[0];
		item.req.node_id      = n[NODE_W-1:0];
		item.gap              = quiet ? 3'd0 : 3'($urandom_range(0, 6));
		item.drain            = drain;
		pending.push_back(item);
		void'(serve_request(item.req));
	endfunction

	function automatic void build_stimulus();
		node_list_t picks;
		int         c;
		int         qs;
		int         roll;
		int         pop_cut;
		int         push_cut;
		pool_reset();

		// empty and single-node queues, head/middle/tail removal, misses
		add_item(CMD_POP,    0, 0, 15, 1'b0);
		add_item(CMD_POP,    0, 1, 0,  1'b0);
		add_item(CMD_PUSH,   0, 1, 0,  1'b0);
		add_item(CMD_POP,    0, 0, 7,  1'b0);
		add_item(CMD_PUSH,   0, 1, 1,  1'b0);
		add_item(CMD_REMOVE, 0, 1, 1,  1'b0);
		add_item(CMD_REMOVE, 0, 1, 0,  1'b0);
		add_item(CMD_POP,    0, 1, 0,  1'b0);
		add_item(CMD_REMOVE, 0, 1, 0,  1'b0);
		add_item(CMD_PUSH,   0, 0, 0,  1'b0);
		add_item(CMD_PUSH,   0, 0, 1,  1'b0);
		add_item(CMD_REMOVE, 3, 0, 15, 1'b0);
		add_item(CMD_REMOVE, 3, 0, 0,  1'b0);
		add_item(CMD_REMOVE, 3, 0, 7,  1'b0);
		add_item(CMD_REMOVE, 3, 0, 7,  1'b0);
		add_item(CMD_REMOVE, 3, 1, 15, 1'b0);
		add_item(CMD_NOP,    2, 1, 15, 1'b0);
		add_item(CMD_NOP,    1, 0, 0,  1'b0);
		// pushing a node that is still queued leaves the free queue malformed
		add_item(CMD_PUSH,   2, 1, 5,  1'b0);
		add_item(CMD_REMOVE, 2, 0, 9,  1'b0);
		add_item(CMD_PUSH,   2, 0, 15, 1'b0);
		add_item(CMD_REMOVE, 2, 1, 5,  1'b0);
		add_item(CMD_POP,    2, 0, 10, 1'b0);

		for (int i = 0; i < 1680; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			// alternate balanced, fill and drain phases
			case ((i / 150) % 3)
				0: begin pop_cut = 35; push_cut = 65; end
				1: begin pop_cut = 20; push_cut = 70; end
				default: begin pop_cut = 55; push_cut = 70; end
			endcase
			c    = $urandom_range(0, CORES - 1);
			qs   = $urandom_range(0, 1);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				add_item(CMD_PUSH, c, qs, $urandom_range(0, NODES - 1), i % 800 == 0);
			end else if (roll < 7) begin
				add_item(CMD_NOP, c, qs, $urandom_range(0, NODES - 1), i % 800 == 0);
			end else if (roll < pop_cut) begin
				add_item(CMD_POP, c, qs, $urandom_range(0, NODES - 1), i % 800 == 0);
			end else if (roll < push_cut) begin
				picks = loose_nodes(c);
				if (picks.size() > 0)
					add_item(CMD_PUSH, c, qs, picks[$urandom_range(0, picks.size() - 1)],
						i % 800 == 0);
				else
					add_item(CMD_POP, c, qs, 0, i % 800 == 0);
			end else begin
				picks = queue_nodes(c, qs);
				if (picks.size() > 0 && $urandom_range(0, 3) != 0)
					add_item(CMD_REMOVE, c, qs, picks[$urandom_range(0, picks.size() - 1)],
						i % 800 == 0);
				else
					add_item(CMD_REMOVE, c, qs, $urandom_range(0, NODES - 1), i % 800 == 0);
			end
		end
		pool_reset();
	endfunction

	// driver: one item in flight at a time, gap counted from acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			request   <= '0;
			idle_left = 0;
		end else if (!(start && busy)) begin
			if (start) begin
				results_due.push_back(serve_request(request));
				pending.delete(0);
				if (pending.size() > 0)
					idle_left = pending[0].gap;
			end
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending.size() > 0
					&& (!pending[0].drain || (results_due.size() == 0 && !done))) begin
				start   <= 1'b1;
				request <= pending[0].req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobe must match the oldest outstanding item
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: node %0d status %0d",
						result.node_out, result.status);
			end else begin
				want = results_due.pop_front();
				if (result.node_out !== want.node_out || result.status !== want.status) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected node %0d status %0d, got node %0d status %0d",
							want.node_out, want.status, result.node_out, result.status);
				end
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending.size() > 0)
			@(posedge clk);
		while (results_due.size() > 0)
			@(posedge clk);
		repeat (2 * NODES + 10) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("testbench: errors");
		$finish;
	end

endmodule
